// File: design/hjds_pkg.sv
// Shared types, constants and hash step for the hashed jitter deadline scheduler.
package hjds_pkg;

    localparam int HASH_W      = 64;
    localparam int TIME_W      = 48;
    localparam int DUE_W       = 49;
    localparam int SEQ_W       = 32;
    localparam int CFG_W       = 32;
    localparam int MAG_W       = CFG_W - 1;
    localparam int CNT_W       = $clog2(HASH_W);
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [HASH_W-1:0] FNV_BASIS = 64'hcbf29ce484222325;
    localparam logic [7:0]        FNV_PRIME_LO = 8'hb3;
    localparam int                FNV_SHIFT_HI = 40;
    localparam int                FNV_SHIFT_MID = 8;

    typedef enum logic [1:0] {
        REG_CADENCE = 2'd0,
        REG_JITTER  = 2'd1,
        REG_SWEEP   = 2'd2
    } cfg_index_t;

    typedef struct packed {
        logic [7:0]        id_byte;
        logic              byte_valid;
        logic              last;
        logic [TIME_W-1:0] completed_at_ms;
        logic [SEQ_W-1:0]  seq_number;
    } in_word_t;

    typedef struct packed {
        logic [HASH_W-1:0] ident_hash;
        logic [DUE_W-1:0]  next_due_ms;
        logic [DUE_W-1:0]  deadline_ms;
        logic [SEQ_W-1:0]  seq_out;
    } out_word_t;

    typedef struct packed {
        logic [HASH_W-1:0] ident_hash;
        logic [TIME_W-1:0] completed_at_ms;
        logic [SEQ_W-1:0]  seq_number;
    } job_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_stat_t;

    typedef struct packed {
        logic [MAG_W-1:0] cadence;
        logic [MAG_W-1:0] window;
        logic [MAG_W-1:0] sweep;
    } cfg_t;

    function automatic logic [MAG_W-1:0] clamp_nonneg(input logic [CFG_W-1:0] raw);
        clamp_nonneg = raw[CFG_W-1] ? '0 : raw[MAG_W-1:0];
    endfunction

    // xor in the byte, then multiply by prime 2^40 + 2^8 + 0xb3
    function automatic logic [HASH_W-1:0] fnv_step(input logic [HASH_W-1:0] h,
                                                   input logic [7:0] b);
        logic [HASH_W-1:0] x;
        logic [HASH_W-1:0] lo;
        x = h ^ {{(HASH_W-8){1'b0}}, b};
        lo = x * {{(HASH_W-8){1'b0}}, FNV_PRIME_LO};
        fnv_step = (x << FNV_SHIFT_HI) + (x << FNV_SHIFT_MID) + lo;
    endfunction

endpackage

// File: design/hjds_front.sv
// Front end: accepts identifier bytes and folds them into the running FNV-1a hash.
module hjds_front
    import hjds_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_stall,
    input  in_word_t in_word,
    input  q_stat_t  q_stat,
    output logic     push,
    output job_t     push_word
);

    logic [HASH_W-1:0] hash_reg;
    logic [HASH_W-1:0] hash_next;
    logic [HASH_W-1:0] folded;
    logic              accept;

    assign in_stall = q_stat.full;
    assign accept   = in_valid && !q_stat.full;
    assign folded   = in_word.byte_valid ? fnv_step(hash_reg, in_word.id_byte) : hash_reg;

    assign push                      = accept && in_word.last;
    assign push_word.ident_hash      = folded;
    assign push_word.completed_at_ms = in_word.completed_at_ms;
    assign push_word.seq_number      = in_word.seq_number;

    always_comb
    begin
        hash_next = hash_reg;
        if (accept)
        begin
            hash_next = in_word.last ? FNV_BASIS : folded;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hash_reg <= FNV_BASIS;
        end
        else
        begin
            hash_reg <= hash_next;
        end
    end

endmodule

// File: design/hjds_queue.sv
// Short job queue between the hashing front end and the scheduling back end.
module hjds_queue
    import hjds_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    push,
    input  job_t    push_word,
    input  logic    pop,
    output job_t    pop_word,
    output q_stat_t q_stat
);

    job_t              entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_next;
    logic [QCNT_W-1:0] count_reg;
    logic [QCNT_W-1:0] count_next;

    assign q_stat.full  = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign q_stat.empty = (count_reg == '0);
    assign pop_word     = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_word;
        end
    end

endmodule

// File: design/hjds_back.sv
// Back end: hash modulo window by restoring division, due and deadline sums, output register.
module hjds_back
    import hjds_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  cfg_t      cfg,
    input  q_stat_t   q_stat,
    input  job_t      pop_word,
    output logic      pop,
    output logic      out_valid,
    input  logic      out_stall,
    output out_word_t out_word
);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_DIV  = 4'b0010,
        S_DUE  = 4'b0100,
        S_LOAD = 4'b1000
    } state_t;

    state_t            state_reg;
    state_t            state_next;
    logic [CNT_W-1:0]  cnt_reg;
    logic [CNT_W-1:0]  cnt_next;
    logic              out_valid_reg;
    logic              out_valid_next;
    logic [HASH_W-1:0] hash_reg;
    logic [HASH_W-1:0] div_reg;
    logic [MAG_W-1:0]  rem_reg;
    logic [TIME_W-1:0] done_reg;
    logic [SEQ_W-1:0]  seq_reg;
    logic [DUE_W-1:0]  due_reg;
    out_word_t         out_word_reg;
    logic [MAG_W:0]    trial;
    logic [MAG_W:0]    trial_sub;
    logic [MAG_W-1:0]  rem_step;
    logic              out_free;

    assign out_valid = out_valid_reg;
    assign out_word  = out_word_reg;
    assign out_free  = !out_valid_reg || !out_stall;
    assign pop       = (state_reg == S_IDLE) && !q_stat.empty;

    assign trial     = {rem_reg, div_reg[HASH_W-1]};
    assign trial_sub = trial - {1'b0, cfg.window};
    assign rem_step  = (trial >= {1'b0, cfg.window}) ? trial_sub[MAG_W-1:0] : trial[MAG_W-1:0];

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        out_valid_next = out_valid_reg && out_stall;
        case (state_reg)
            S_IDLE:
            begin
                if (!q_stat.empty)
                begin
                    cnt_next   = '1;
                    state_next = (cfg.window == '0) ? S_DUE : S_DIV;
                end
            end
            S_DIV:
            begin
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    state_next = S_DUE;
                end
            end
            S_DUE:
            begin
                state_next = S_LOAD;
            end
            S_LOAD:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
            begin
                hash_reg <= pop_word.ident_hash;
                div_reg  <= pop_word.ident_hash;
                done_reg <= pop_word.completed_at_ms;
                seq_reg  <= pop_word.seq_number;
                rem_reg  <= '0;
            end
            S_DIV:
            begin
                rem_reg <= rem_step;
                div_reg <= {div_reg[HASH_W-2:0], 1'b0};
            end
            S_DUE:
            begin
                due_reg <= {1'b0, done_reg} + DUE_W'(cfg.cadence) + DUE_W'(rem_reg);
            end
            S_LOAD:
            begin
                if (out_free)
                begin
                    out_word_reg.ident_hash  <= hash_reg;
                    out_word_reg.next_due_ms <= due_reg;
                    out_word_reg.deadline_ms <= due_reg + DUE_W'(cfg.sweep);
                    out_word_reg.seq_out     <= seq_reg;
                end
            end
            default:
            begin
                rem_reg <= '0;
            end
        endcase
    end

endmodule

// File: design/hashed_jitter_deadline_scheduler_unit.sv
// Top level of the hashed jitter deadline scheduler.
// Throughput: one identifier byte per cycle into the hash while the queue is not
// full; each identifier then passes S_DIV, the one-bit-per-cycle 64-bit modulo
// divider, unless the jitter window is non-positive, then S_DUE and S_LOAD.
// A 2-entry queue overlaps them. Out_stall can hold a result in S_LOAD.
// Reset: asynchronous; settings and control state cleared, hash set to FNV basis.
module hashed_jitter_deadline_scheduler_unit
    import hjds_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  in_word_t          in_word,
    output logic              out_valid,
    input  logic              out_stall,
    output out_word_t         out_word,
    input  logic              cfg_we,
    input  logic [1:0]        cfg_index,
    input  logic [CFG_W-1:0]  cfg_data
);

    logic [CFG_W-1:0] cadence_reg;
    logic [CFG_W-1:0] window_reg;
    logic [CFG_W-1:0] sweep_reg;
    cfg_t             cfg;
    q_stat_t          q_stat;
    logic             push;
    logic             pop;
    job_t             push_word;
    job_t             pop_word;

    assign cfg.cadence = clamp_nonneg(cadence_reg);
    assign cfg.window  = clamp_nonneg(window_reg);
    assign cfg.sweep   = clamp_nonneg(sweep_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cadence_reg <= '0;
            window_reg  <= '0;
            sweep_reg   <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_CADENCE: cadence_reg <= cfg_data;
                REG_JITTER:  window_reg  <= cfg_data;
                REG_SWEEP:   sweep_reg   <= cfg_data;
                default:     cadence_reg <= cadence_reg;
            endcase
        end
    end

    hjds_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_word   (in_word),
        .q_stat    (q_stat),
        .push      (push),
        .push_word (push_word)
    );

    hjds_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_word (push_word),
        .pop       (pop),
        .pop_word  (pop_word),
        .q_stat    (q_stat)
    );

    hjds_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .q_stat    (q_stat),
        .pop_word  (pop_word),
        .pop       (pop),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_word  (out_word)
    );

endmodule

// File: design/hjds_checker.sv
// Port-level assertions for the hashed jitter deadline scheduler, bound to the top level.
module hjds_checker
    import hjds_pkg::*;
(
    input logic      clk,
    input logic      rst_n,
    input logic      in_valid,
    input logic      in_stall,
    input in_word_t  in_word,
    input logic      out_valid,
    input logic      out_stall,
    input out_word_t out_word
);

    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_stall |=> in_valid && $stable(in_word))
        else $error("input word changed while stalled");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("result dropped while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> $stable(out_word))
        else $error("result word changed while stalled");

    a_deadline_span: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_word.deadline_ms >= out_word.next_due_ms) &&
                      ((out_word.deadline_ms - out_word.next_due_ms) < 49'h80000000))
        else $error("deadline not within sweep allowance of due time");

    a_ready_after_reset: assert property (@(posedge clk)
        rst_n && !$past(rst_n) |-> !in_stall)
        else $error("input stalled right after reset");

endmodule

bind hashed_jitter_deadline_scheduler_unit hjds_checker u_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word)
);

// File: test/tb_hashed_jitter_deadline_scheduler_unit.sv
// Testbench for the hashed jitter deadline scheduler: random identifiers checked against a scoreboard.
`timescale 1ns / 1ps

module tb_hashed_jitter_deadline_scheduler_unit
    import hjds_pkg::*;
;

    localparam logic [HASH_W-1:0] HASH_PRIME = 64'h0000_0100_0000_01b3;
    localparam logic [1:0]        REG_SPARE  = 2'd3;
    localparam logic [TIME_W-1:0] TIME_MAX   = {TIME_W{1'b1}};
    localparam logic [SEQ_W-1:0]  SEQ_MAX    = {SEQ_W{1'b1}};
    localparam int ID_WORDS   = 1300;
    localparam int SETTLE     = 80;
    localparam int WATCHDOG   = 3000;
    localparam int STALL_NONE = 0;
    localparam int STALL_SOME = 1;

    class schedule_scoreboard;
        logic [CFG_W-1:0]  cadence;
        logic [CFG_W-1:0]  window;
        logic [CFG_W-1:0]  sweep;
        logic [HASH_W-1:0] id_hash;
        out_word_t         due_words[$];
        int unsigned       errors;

        function new();
            cadence = '0;
            window  = '0;
            sweep   = '0;
            id_hash = FNV_BASIS;
            errors  = 0;
        endfunction

        function void set_reg(input logic [1:0] idx, input logic [CFG_W-1:0] data);
            case (idx)
                REG_CADENCE: cadence = data;
                REG_JITTER:  window  = data;
                REG_SWEEP:   sweep   = data;
                default: ;
            endcase
        endfunction

        function logic [63:0] magnitude(input logic [CFG_W-1:0] raw);
            magnitude = raw[CFG_W-1] ? 64'd0 : {32'd0, raw};
        endfunction

        function void absorb_word(input in_word_t w);
            logic [63:0] span;
            logic [63:0] jitter;
            logic [63:0] due;
            logic [63:0] deadline;
            out_word_t   r;
            if (w.byte_valid)
                id_hash = (id_hash ^ {56'd0, w.id_byte}) * HASH_PRIME;
            if (w.last)
            begin
                span     = magnitude(window);
                jitter   = (span != 0) ? id_hash % span : 64'd0;
                due      = {16'd0, w.completed_at_ms} + magnitude(cadence) + jitter;
                deadline = due + magnitude(sweep);
                r.ident_hash  = id_hash;
                r.next_due_ms = due[DUE_W-1:0];
                r.deadline_ms = deadline[DUE_W-1:0];
                r.seq_out     = w.seq_number;
                due_words.push_back(r);
                id_hash = FNV_BASIS;
            end
        endfunction

        function void flag(input string what, input logic [63:0] exp, input logic [63:0] got);
            errors++;
            if (errors <= 10)
                $display("mismatch %s: expected %h, got %h", what, exp, got);
        endfunction

        function void check_schedule(input out_word_t got);
            out_word_t exp;
            if (due_words.size() == 0)
            begin
                flag("unexpected word hash", 64'd0, got.ident_hash);
                return;
            end
            exp = due_words.pop_front();
            if (exp.ident_hash !== got.ident_hash)
                flag("ident_hash", exp.ident_hash, got.ident_hash);
            if (exp.next_due_ms !== got.next_due_ms)
                flag("next_due_ms", 64'(exp.next_due_ms), 64'(got.next_due_ms));
            if (exp.deadline_ms !== got.deadline_ms)
                flag("deadline_ms", 64'(exp.deadline_ms), 64'(got.deadline_ms));
            if (exp.seq_out !== got.seq_out)
                flag("seq_out", 64'(exp.seq_out), 64'(got.seq_out));
        endfunction

        function int pending();
            pending = due_words.size();
        endfunction
    endclass

    logic             clk       = 1'b0;
    logic             rst_n     = 1'b0;
    logic             in_valid  = 1'b0;
    logic             in_stall;
    in_word_t         in_word   = '0;
    logic             out_valid;
    logic             out_stall = 1'b0;
    out_word_t        out_word;
    logic             cfg_we    = 1'b0;
    logic [1:0]       cfg_index = 2'd0;
    logic [CFG_W-1:0] cfg_data  = '0;

    schedule_scoreboard sb = new();
    int burst_left = 0;
    int words_sent = 0;
    int quiet      = 0;
    int stall_mode = STALL_NONE;
    int mode_left  = 0;

    hashed_jitter_deadline_scheduler_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_word   (in_word),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_word  (out_word),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #5 clk = ~clk;

    function automatic in_word_t make_word(input logic [7:0] b, input logic bv, input logic lst,
                                           input logic [TIME_W-1:0] done_at,
                                           input logic [SEQ_W-1:0] seq);
        in_word_t w;
        w.id_byte         = b;
        w.byte_valid      = bv;
        w.last            = lst;
        w.completed_at_ms = done_at;
        w.seq_number      = seq;
        return w;
    endfunction

    function automatic logic [TIME_W-1:0] pick_time();
        case ($urandom_range(0, 7))
            0: pick_time = TIME_MAX;
            1: pick_time = '0;
            default: pick_time = {16'($urandom()), $urandom()};
        endcase
    endfunction

    function automatic logic [CFG_W-1:0] pick_setting();
        case ($urandom_range(0, 7))
            0: pick_setting = 32'h0000_0000;
            1: pick_setting = 32'h0000_0001;
            2: pick_setting = 32'h7fff_ffff;
            3: pick_setting = 32'h8000_0000;
            4: pick_setting = 32'hffff_ffff;
            5: pick_setting = $urandom_range(1, 64);
            6: pick_setting = $urandom_range(1, 100000);
            default: pick_setting = $urandom();
        endcase
    endfunction

    task automatic send_word(input in_word_t w);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
            burst_left = $urandom_range(1, 24);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        in_valid <= 1'b1;
        in_word  <= w;
        do @(posedge clk); while (in_stall);
        sb.absorb_word(w);
    endtask

    task automatic send_ident(input int nbytes, input logic tail_byte,
                              input logic [TIME_W-1:0] done_at, input logic [SEQ_W-1:0] seq,
                              input int noise_pct);
        in_word_t w;
        for (int k = 0; k < nbytes; k++)
        begin
            if ($urandom_range(0, 99) < noise_pct)
                send_word(make_word(8'($urandom()), 1'b0, 1'b0, pick_time(), $urandom()));
            send_word(make_word(8'($urandom()), 1'b1, 1'b0, pick_time(), $urandom()));
            words_sent++;
        end
        w = make_word(8'($urandom()), tail_byte, 1'b1, done_at, seq);
        send_word(w);
        words_sent++;
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic cfg_write(input logic [1:0] idx, input logic [CFG_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        sb.set_reg(idx, data);
    endtask

    task automatic set_config(input logic [CFG_W-1:0] cad, input logic [CFG_W-1:0] win,
                              input logic [CFG_W-1:0] swp);
        drain();
        cfg_write(REG_CADENCE, cad);
        cfg_write(REG_JITTER, win);
        cfg_write(REG_SWEEP, swp);
        cfg_write(REG_SPARE, $urandom());
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    // hold the receiver in one stall mode for a while, then pick another
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && !out_stall)
                sb.check_schedule(out_word);
            if (mode_left == 0)
            begin
                stall_mode = $urandom_range(0, 2);
                mode_left  = $urandom_range(20, 80);
            end
            else
                mode_left--;
            if (stall_mode == STALL_NONE)
                out_stall <= 1'b0;
            else if (stall_mode == STALL_SOME)
                out_stall <= ($urandom_range(0, 3) == 0);
            else
                out_stall <= ($urandom_range(0, 15) < 12);
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
            quiet <= 0;
        else if (quiet >= WATCHDOG)
        begin
            $display("Simulation FAILED");
            $finish;
        end
        else
            quiet <= quiet + 1;
    end

    initial
    begin
        int phase_end;
        int len;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings: empty identifier, byte extremes, ignored byte, last without byte
        send_word(make_word(8'h00, 1'b0, 1'b1, '0, '0));
        send_word(make_word(8'h00, 1'b1, 1'b0, TIME_MAX, SEQ_MAX));
        send_word(make_word(8'hff, 1'b1, 1'b1, TIME_MAX, SEQ_MAX));
        send_word(make_word(8'ha5, 1'b0, 1'b0, TIME_MAX, 32'h5555_5555));
        send_word(make_word(8'h5a, 1'b1, 1'b1, 48'h1234_5678_9abc, 32'haaaa_aaaa));
        send_word(make_word(8'h61, 1'b1, 1'b0, '0, '0));
        send_word(make_word(8'h62, 1'b1, 1'b0, '0, '0));
        send_word(make_word(8'h77, 1'b0, 1'b1, 48'd1000, 32'd7));

        set_config(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
        send_ident(3, 1'b1, TIME_MAX, SEQ_MAX, 0);
        send_ident(0, 1'b0, TIME_MAX, 32'd1, 0);
        set_config(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
        send_ident(2, 1'b0, 48'h8000_0000_0000, 32'd2, 0);
        set_config(32'hffff_ffff, 32'h0000_0001, 32'h0000_0000);
        send_ident(2, 1'b1, 48'd5, 32'd3, 0);
        set_config(32'd1000, 32'd7, 32'hffff_ffff);
        send_ident(3, 1'b1, 48'd12345, 32'd4, 0);

        phase_end = words_sent;
        while (words_sent < ID_WORDS)
        begin
            if (words_sent >= phase_end)
            begin
                set_config(pick_setting(), pick_setting(), pick_setting());
                phase_end = words_sent + $urandom_range(100, 200);
            end
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(0, 12);
            send_ident(len, 1'($urandom_range(0, 1)), pick_time(), $urandom(), 10);
        end

        drain();
        if (sb.errors == 0 && sb.pending() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
